FILE: sv/ols_pkg.sv
// ols_pkg: shared types and codes for the ordered list store.
// Request and response payload structs, operation and status codes, cell operations.
// No dependencies.
package ols_pkg;

    localparam logic [2:0] KIND_APPEND     = 3'd0;
    localparam logic [2:0] KIND_INSERT_AT  = 3'd1;
    localparam logic [2:0] KIND_REMOVE_VAL = 3'd2;
    localparam logic [2:0] KIND_REMOVE_AT  = 3'd3;
    localparam logic [2:0] KIND_READ_AT    = 3'd4;
    localparam logic [2:0] KIND_FIND       = 3'd5;
    localparam logic [2:0] KIND_CLEAR      = 3'd6;

    localparam logic [1:0] STAT_OK        = 2'd0;
    localparam logic [1:0] STAT_RANGE     = 2'd1;
    localparam logic [1:0] STAT_NOT_FOUND = 2'd2;
    localparam logic [1:0] STAT_FULL      = 2'd3;

    typedef struct packed {
        logic [2:0]  kind;
        logic [6:0]  position;
        logic [31:0] value;
    } t_req;

    typedef struct packed {
        logic [1:0]  status;
        logic [5:0]  found_position;
        logic [31:0] read_value;
        logic [6:0]  entry_count;
    } t_rsp;

    typedef enum logic [2:0] {
        CELL_HOLD   = 3'd0,
        CELL_ROTATE = 3'd1,
        CELL_INSERT = 3'd2,
        CELL_DELETE = 3'd3,
        CELL_CLEAR  = 3'd4
    } t_cell_op;

endpackage

FILE: sv/ols_cell.sv
// ols_cell: one list entry of the cell chain.
// Takes its left or right neighbor, the request value, or zero, per broadcast operation.
// Depends on ols_pkg.
module ols_cell #(
    parameter int INDEX     = 0,
    parameter int IW        = 6,
    parameter int ITEM_BITS = 32
) (
    input  logic                  i_clk,
    input  ols_pkg::t_cell_op     i_op,
    input  logic [IW-1:0]         i_pos,
    input  logic [ITEM_BITS-1:0]  i_value,
    input  logic [ITEM_BITS-1:0]  i_left,
    input  logic [ITEM_BITS-1:0]  i_right,
    output logic [ITEM_BITS-1:0]  o_data
);
    import ols_pkg::*;

    localparam logic [IW-1:0] INDEX_V = IW'(INDEX);

    logic [ITEM_BITS-1:0] r_data;
    logic [ITEM_BITS-1:0] n_data;

    always_comb begin
        n_data = r_data;
        unique case (i_op)
            CELL_HOLD: begin
                n_data = r_data;
            end
            CELL_ROTATE: begin
                n_data = i_right;
            end
            CELL_INSERT: begin
                if (INDEX_V > i_pos) begin
                    n_data = i_left;
                end else if (INDEX_V == i_pos) begin
                    n_data = i_value;
                end
            end
            CELL_DELETE: begin
                if (INDEX_V >= i_pos) begin
                    n_data = i_right;
                end
            end
            CELL_CLEAR: begin
                n_data = '0;
            end
            default: begin
                n_data = r_data;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_data <= n_data;
    end

    assign o_data = r_data;

endmodule

FILE: sv/ordered_list_store.sv
// ordered_list_store: bounded ordered list built as a chain of entry cells plus a controller.
// Depends on ols_pkg and ols_cell.
//
// Append, insert at, remove at, clear, unknown kinds and out-of-range requests complete
// on acceptance: every cell shifts or loads in parallel and the response register is loaded at
// the accepting edge. Read at (in range), find and remove value go through S_SCAN, then S_APPLY:
// the whole chain rotates once, one cell per cycle, past the head cell where the single
// comparator and read capture sit, then S_APPLY loads the response (and does the removal
// shift). A new request is taken when the controller is idle and the response register is
// empty or being emptied. No clearing pass follows reset.
module ordered_list_store #(
    parameter int CAPACITY  = 64,
    parameter int ITEM_BITS = 32
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_req_valid,
    output logic          o_req_ready,
    input  ols_pkg::t_req i_req,
    output logic          o_rsp_valid,
    input  logic          i_rsp_ready,
    output ols_pkg::t_rsp o_rsp
);
    import ols_pkg::*;

    localparam int IW   = $clog2(CAPACITY);
    localparam int CNTW = $clog2(CAPACITY + 1);
    localparam int CMPW = (CNTW > 7) ? CNTW : 7;
    localparam logic [IW-1:0]   LAST_V = IW'(CAPACITY - 1);
    localparam logic [CNTW-1:0] CAP_V  = CNTW'(CAPACITY);

    typedef enum logic [2:0] {
        S_IDLE  = 3'b001,
        S_SCAN  = 3'b010,
        S_APPLY = 3'b100
    } t_state;

    t_state                r_state, n_state;
    logic [CNTW-1:0]       r_count, n_count;
    logic [2:0]            r_kind, n_kind;
    logic [IW-1:0]         r_pos, n_pos;
    logic [ITEM_BITS-1:0]  r_item, n_item;
    logic [IW-1:0]         r_scan, n_scan;
    logic                  r_found, n_found;
    logic [IW-1:0]         r_idx, n_idx;
    logic [ITEM_BITS-1:0]  r_rd, n_rd;
    t_rsp                  r_out;
    logic                  r_out_valid;

    t_cell_op              cell_op;
    logic [IW-1:0]         cell_pos;
    logic [ITEM_BITS-1:0]  cell_val;
    logic [ITEM_BITS-1:0]  cell_q [CAPACITY];

    logic                  req_acc;
    logic [CMPW-1:0]       pos_x, cnt_x, idx_x, cntn_x;
    logic [ITEM_BITS-1:0]  v_item;
    logic                  full;
    logic                  head_live;
    logic                  rsp_wr;
    logic [1:0]            rsp_status;
    logic [IW-1:0]         rsp_found;
    logic [ITEM_BITS-1:0]  rsp_rd;
    t_rsp                  rsp;

    assign o_req_ready = (r_state == S_IDLE) && (!r_out_valid || i_rsp_ready);
    assign req_acc     = i_req_valid && o_req_ready;
    assign pos_x       = CMPW'(i_req.position);
    assign cnt_x       = CMPW'(r_count);
    assign v_item      = ITEM_BITS'(i_req.value);
    assign full        = (r_count == CAP_V);
    assign head_live   = CNTW'(r_scan) < r_count;

    genvar g;
    generate
        for (g = 0; g < CAPACITY; g++) begin : g_cell
            logic [ITEM_BITS-1:0] left_d;
            logic [ITEM_BITS-1:0] right_d;
            if (g == 0) begin : g_first
                assign left_d = '0;
            end else begin : g_inner_l
                assign left_d = cell_q[g-1];
            end
            if (g == CAPACITY - 1) begin : g_last
                assign right_d = cell_q[0];
            end else begin : g_inner_r
                assign right_d = cell_q[g+1];
            end
            ols_cell #(
                .INDEX     (g),
                .IW        (IW),
                .ITEM_BITS (ITEM_BITS)
            ) u_cell (
                .i_clk   (i_clk),
                .i_op    (cell_op),
                .i_pos   (cell_pos),
                .i_value (cell_val),
                .i_left  (left_d),
                .i_right (right_d),
                .o_data  (cell_q[g])
            );
        end
    endgenerate

    always_comb begin
        n_state    = r_state;
        n_count    = r_count;
        n_kind     = r_kind;
        n_pos      = r_pos;
        n_item     = r_item;
        n_scan     = r_scan;
        n_found    = r_found;
        n_idx      = r_idx;
        n_rd       = r_rd;
        cell_op    = CELL_HOLD;
        cell_pos   = r_pos;
        cell_val   = r_item;
        rsp_wr     = 1'b0;
        rsp_status = STAT_OK;
        rsp_found  = '0;
        rsp_rd     = '0;
        unique case (r_state)
            S_IDLE: begin
                if (req_acc) begin
                    n_kind   = i_req.kind;
                    n_pos    = pos_x[IW-1:0];
                    n_item   = v_item;
                    n_scan   = '0;
                    n_found  = 1'b0;
                    n_idx    = '0;
                    n_rd     = '0;
                    cell_val = v_item;
                    cell_pos = pos_x[IW-1:0];
                    rsp_wr   = 1'b1;
                    unique case (i_req.kind) inside
                        KIND_APPEND: begin
                            if (full) begin
                                rsp_status = STAT_FULL;
                            end else begin
                                cell_op  = CELL_INSERT;
                                cell_pos = cnt_x[IW-1:0];
                                n_count  = r_count + CNTW'(1);
                            end
                        end
                        KIND_INSERT_AT: begin
                            if (pos_x > cnt_x) begin
                                rsp_status = STAT_RANGE;
                            end else if (full) begin
                                rsp_status = STAT_FULL;
                            end else begin
                                cell_op = CELL_INSERT;
                                n_count = r_count + CNTW'(1);
                            end
                        end
                        KIND_REMOVE_AT: begin
                            if (pos_x >= cnt_x) begin
                                rsp_status = STAT_RANGE;
                            end else begin
                                cell_op = CELL_DELETE;
                                n_count = r_count - CNTW'(1);
                            end
                        end
                        KIND_READ_AT: begin
                            if (pos_x >= cnt_x) begin
                                rsp_status = STAT_RANGE;
                            end else begin
                                rsp_wr  = 1'b0;
                                n_state = S_SCAN;
                            end
                        end
                        KIND_REMOVE_VAL, KIND_FIND: begin
                            rsp_wr  = 1'b0;
                            n_state = S_SCAN;
                        end
                        KIND_CLEAR: begin
                            cell_op = CELL_CLEAR;
                            n_count = '0;
                        end
                        default: begin
                            rsp_status = STAT_OK;
                        end
                    endcase
                end
            end
            S_SCAN: begin
                cell_op = CELL_ROTATE;
                if (head_live && !r_found && (cell_q[0] == r_item)) begin
                    n_found = 1'b1;
                    n_idx   = r_scan;
                end
                if (r_scan == r_pos) begin
                    n_rd = cell_q[0];
                end
                if (r_scan == LAST_V) begin
                    n_state = S_APPLY;
                end else begin
                    n_scan = r_scan + IW'(1);
                end
            end
            S_APPLY: begin
                rsp_wr  = 1'b1;
                n_state = S_IDLE;
                if (r_kind == KIND_READ_AT) begin
                    rsp_rd = r_rd;
                end else if (r_found) begin
                    rsp_found = r_idx;
                    if (r_kind == KIND_REMOVE_VAL) begin
                        cell_op  = CELL_DELETE;
                        cell_pos = r_idx;
                        n_count  = r_count - CNTW'(1);
                    end
                end else begin
                    rsp_status = STAT_NOT_FOUND;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    assign idx_x  = CMPW'(rsp_found);
    assign cntn_x = CMPW'(n_count);

    always_comb begin
        rsp.status         = rsp_status;
        rsp.found_position = idx_x[5:0];
        rsp.read_value     = 32'(rsp_rd);
        rsp.entry_count    = cntn_x[6:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_count     <= '0;
            r_found     <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
            r_found <= n_found;
            if (rsp_wr) begin
                r_out_valid <= 1'b1;
            end else if (i_rsp_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_kind <= n_kind;
        r_pos  <= n_pos;
        r_item <= n_item;
        r_scan <= n_scan;
        r_idx  <= n_idx;
        r_rd   <= n_rd;
        if (rsp_wr) begin
            r_out <= rsp;
        end
    end

    assign o_rsp_valid = r_out_valid;
    assign o_rsp       = r_out;

`ifndef SYNTH
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CAP_V)
        else $error("live count above capacity");

    a_rsp_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !i_rsp_ready) |=> (r_out_valid && $stable(r_out)))
        else $error("pending response overwritten");

    a_scan_count_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SCAN) |=> $stable(r_count))
        else $error("count changed during rotation");

    a_found_live: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_APPLY && r_found) |-> (CNTW'(r_idx) < r_count))
        else $error("match index beyond live entries");
`endif

endmodule

FILE: tb/ordered_list_store_tb.sv
// ordered_list_store_tb: self-checking testbench for the ordered list store.
// Tracks the list in a local model, predicts every response and compares it field by field.
// Depends on ols_pkg and the ordered_list_store RTL.
`timescale 1ns / 100ps

module ordered_list_store_tb;
    import ols_pkg::*;

    localparam int LIST_CAP = 64;
    localparam logic [2:0] KIND_UNUSED = 3'd7;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic i_req_valid = 1'b0;
    logic o_req_ready;
    t_req i_req = '0;
    logic o_rsp_valid;
    logic i_rsp_ready = 1'b0;
    t_rsp o_rsp;

    logic [31:0] list_words [LIST_CAP];
    int list_len = 0;
    t_rsp op_outcomes [$];
    int mismatch_count = 0;
    int req_idle_pct = 0;
    int rsp_stall_pct = 0;

    ordered_list_store #(
        .CAPACITY (LIST_CAP),
        .ITEM_BITS(32)
    ) uut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_req_valid(i_req_valid),
        .o_req_ready(o_req_ready),
        .i_req      (i_req),
        .o_rsp_valid(o_rsp_valid),
        .i_rsp_ready(i_rsp_ready),
        .o_rsp      (o_rsp)
    );

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    function automatic void drop_entry(input int at);
        for (int i = at; i < list_len - 1; i++) begin
            list_words[i] = list_words[i + 1];
        end
        list_len--;
    endfunction

    // Applies one request to the local list and returns the response it should produce.
    function automatic t_rsp apply_list_op(input t_req r);
        t_rsp rsp;
        int hit;
        rsp = '0;
        hit = -1;
        for (int i = list_len - 1; i >= 0; i--) begin
            if (list_words[i] == r.value) hit = i;
        end
        case (r.kind)
            KIND_APPEND: begin
                if (list_len >= LIST_CAP) begin
                    rsp.status = STAT_FULL;
                end else begin
                    list_words[list_len] = r.value;
                    list_len++;
                end
            end
            KIND_INSERT_AT: begin
                if (r.position > list_len) begin
                    rsp.status = STAT_RANGE;
                end else if (list_len >= LIST_CAP) begin
                    rsp.status = STAT_FULL;
                end else begin
                    for (int i = list_len; i > r.position; i--) begin
                        list_words[i] = list_words[i - 1];
                    end
                    list_words[r.position] = r.value;
                    list_len++;
                end
            end
            KIND_REMOVE_VAL: begin
                if (hit < 0) begin
                    rsp.status = STAT_NOT_FOUND;
                end else begin
                    rsp.found_position = hit[5:0];
                    drop_entry(hit);
                end
            end
            KIND_REMOVE_AT: begin
                if (r.position >= list_len) rsp.status = STAT_RANGE;
                else drop_entry(r.position);
            end
            KIND_READ_AT: begin
                if (r.position >= list_len) rsp.status = STAT_RANGE;
                else rsp.read_value = list_words[r.position];
            end
            KIND_FIND: begin
                if (hit < 0) rsp.status = STAT_NOT_FOUND;
                else rsp.found_position = hit[5:0];
            end
            KIND_CLEAR: begin
                for (int i = 0; i < LIST_CAP; i++) begin
                    list_words[i] = '0;
                end
                list_len = 0;
            end
            default: begin
            end
        endcase
        rsp.entry_count = list_len[6:0];
        return rsp;
    endfunction

    // Mostly words already in the list or a small set, so finds and removes hit.
    function automatic logic [31:0] pick_value();
        case ($urandom_range(9)) inside
            0: return $urandom;
            [1:2]: return $urandom_range(15);
            default: begin
                if (list_len > 0) return list_words[$urandom_range(list_len - 1)];
                return $urandom_range(15);
            end
        endcase
    endfunction

    function automatic logic [6:0] pick_position();
        if ($urandom_range(3) == 0) return 7'($urandom_range(LIST_CAP));
        return 7'($urandom_range(list_len));
    endfunction

    function automatic t_req random_request(input int add_pct, input int drop_pct);
        t_req r;
        int roll;
        roll = $urandom_range(99);
        r.position = pick_position();
        r.value = pick_value();
        if (roll < add_pct) begin
            r.kind = $urandom_range(1) ? KIND_APPEND : KIND_INSERT_AT;
        end else if (roll < add_pct + drop_pct) begin
            r.kind = $urandom_range(1) ? KIND_REMOVE_VAL : KIND_REMOVE_AT;
        end else begin
            case ($urandom_range(19)) inside
                0: r.kind = KIND_CLEAR;
                1: r.kind = KIND_UNUSED;
                [2:9]: r.kind = KIND_READ_AT;
                default: r.kind = KIND_FIND;
            endcase
        end
        return r;
    endfunction

    task automatic send_request(input t_req r);
        while ($urandom_range(99) < req_idle_pct) begin
            i_req_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_req_valid <= 1'b1;
        i_req <= r;
        @(posedge i_clk);
        while (!o_req_ready) @(posedge i_clk);
        op_outcomes.push_back(apply_list_op(r));
    endtask

    task automatic send_op(input logic [2:0] kind, input logic [6:0] pos,
                           input logic [31:0] val);
        t_req r;
        r.kind = kind;
        r.position = pos;
        r.value = val;
        send_request(r);
    endtask

    always @(posedge i_clk) begin : rsp_monitor
        t_rsp want;
        if (i_rst_n && o_rsp_valid && i_rsp_ready) begin
            if (op_outcomes.size() == 0) begin
                $error("response with no request outstanding: %p", o_rsp);
                mismatch_count++;
            end else begin
                want = op_outcomes.pop_front();
                if (o_rsp.status !== want.status) begin
                    $error("status: expected %0d, got %0d", want.status, o_rsp.status);
                    mismatch_count++;
                end
                if (o_rsp.found_position !== want.found_position) begin
                    $error("found_position: expected %0d, got %0d",
                           want.found_position, o_rsp.found_position);
                    mismatch_count++;
                end
                if (o_rsp.read_value !== want.read_value) begin
                    $error("read_value: expected %h, got %h", want.read_value, o_rsp.read_value);
                    mismatch_count++;
                end
                if (o_rsp.entry_count !== want.entry_count) begin
                    $error("entry_count: expected %0d, got %0d",
                           want.entry_count, o_rsp.entry_count);
                    mismatch_count++;
                end
            end
        end
        i_rsp_ready <= ($urandom_range(99) >= rsp_stall_pct);
    end

    task automatic test_corner_cases();
        send_op(KIND_READ_AT, 7'd0, 32'h0);
        send_op(KIND_REMOVE_AT, 7'd0, 32'h0);
        send_op(KIND_FIND, 7'd0, 32'h0);
        send_op(KIND_REMOVE_VAL, 7'd5, 32'h0);
        send_op(KIND_INSERT_AT, 7'd1, 32'h1234_5678);
        send_op(KIND_UNUSED, 7'd0, 32'h0);
        send_op(KIND_INSERT_AT, 7'd0, 32'hFFFF_FFFF);
        send_op(KIND_APPEND, 7'd127, 32'h0);
        send_op(KIND_APPEND, 7'd64, 32'hA5A5_5A5A);
        send_op(KIND_INSERT_AT, 7'd3, 32'h5A5A_A5A5);
        send_op(KIND_INSERT_AT, 7'd64, 32'hDEAD_BEEF);
        send_op(KIND_INSERT_AT, 7'd1, 32'h0000_0001);
        send_op(KIND_FIND, 7'd64, 32'hA5A5_5A5A);
        send_op(KIND_READ_AT, 7'd0, 32'hFFFF_FFFF);
        send_op(KIND_READ_AT, 7'd4, 32'h0);
        send_op(KIND_READ_AT, 7'd5, 32'h0);
        send_op(KIND_READ_AT, 7'd64, 32'h0);
        send_op(KIND_APPEND, 7'd0, 32'hFFFF_FFFF);
        send_op(KIND_REMOVE_VAL, 7'd0, 32'hFFFF_FFFF);
        send_op(KIND_REMOVE_AT, 7'd0, 32'hFFFF_FFFF);
        send_op(KIND_REMOVE_AT, 7'd3, 32'h0);
        send_op(KIND_UNUSED, 7'd127, 32'hFFFF_FFFF);
        send_op(KIND_CLEAR, 7'd64, 32'hFFFF_FFFF);
        send_op(KIND_READ_AT, 7'd0, 32'h0);
        send_op(KIND_FIND, 7'd0, 32'h0);
    endtask

    // Grow the list until full requests have been rejected four times, then empty it.
    task automatic test_fill_and_drain();
        t_req r;
        int full_hits;
        full_hits = 0;
        while (full_hits < 4) begin
            r = random_request(85, 10);
            if (list_len == LIST_CAP && (r.kind == KIND_APPEND || r.kind == KIND_INSERT_AT))
                full_hits++;
            send_request(r);
        end
        while (list_len > 0) begin
            send_request(random_request(10, 80));
        end
    endtask

    task automatic test_random_mix(input int n);
        repeat (n) send_request(random_request(35, 35));
    endtask

    initial begin
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;

        req_idle_pct = 22;
        rsp_stall_pct = 50;
        test_corner_cases();
        test_fill_and_drain();
        test_random_mix(10);

        req_idle_pct = 50;
        rsp_stall_pct = 22;
        test_random_mix(60);

        req_idle_pct = 0;
        rsp_stall_pct = 0;
        test_fill_and_drain();
        test_random_mix(10);

        i_req_valid <= 1'b0;
        while (op_outcomes.size() != 0) @(posedge i_clk);
        repeat (LIST_CAP + 8) @(posedge i_clk);
        if (mismatch_count == 0) begin
            $display("end of test: clean");
        end else begin
            $display("end of test: mismatches");
        end
        $finish;
    end

    initial begin
        #5_000_000;
        $display("end of test: mismatches");
        $finish;
    end

endmodule
